// ===== rtl/lppe_pkg.sv =====
// ----------------------------------------------------------------------------
// lppe_pkg
// Types and constants shared by the LED pixel PWM encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lppe_pkg;

    // Input item: one LED pixel or one blank slot
    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] absolute_level;
        logic [7:0] relative_level;
    } t_pixel;

    // Result item: one timer compare word
    typedef struct packed {
        logic [15:0] duty;
        logic        last;
    } t_word;

    // Scaled channels handed from the scaler to the serializer
    typedef struct packed {
        logic       blank;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_scaled;

    // Configuration register values
    typedef struct packed {
        logic [1:0]  color_order;
        logic [15:0] zero_bit_duty;
        logic [15:0] one_bit_duty;
    } t_cfg;

    // Register indexes
    localparam logic [1:0] CFG_COLOR_ORDER = 2'd0;
    localparam logic [1:0] CFG_ZERO_DUTY   = 2'd1;
    localparam logic [1:0] CFG_ONE_DUTY    = 2'd2;

    // Reset values
    localparam logic [1:0]  RST_COLOR_ORDER = 2'd0;
    localparam logic [15:0] RST_ZERO_DUTY   = 16'd30;
    localparam logic [15:0] RST_ONE_DUTY    = 16'd60;

    // Wire order codes
    localparam logic [1:0] ORDER_RGB = 2'd0;
    localparam logic [1:0] ORDER_RBG = 2'd1;
    localparam logic [1:0] ORDER_BRG = 2'd2;
    localparam logic [1:0] ORDER_GRB = 2'd3;

    // Serializer
    localparam int         BITS_PER_LED = 24;
    localparam logic [4:0] LAST_BIT     = 5'(BITS_PER_LED - 1);

    // Division by 2550: below 256*2550 the quotient is (p * RECIP) >> 32,
    // exact for any p under 2^20; at or above it the channel saturates.
    localparam logic [23:0] SAT_LIMIT = 24'd652800;
    localparam logic [20:0] RECIP     = 21'd1684301;
    localparam logic [7:0]  CH_MAX    = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/lppe_scale.sv =====
// ----------------------------------------------------------------------------
// lppe_scale
// Three-stage brightness scaler: channel*relative, times absolute, then
// division by 2550 through a reciprocal multiply with saturation at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_scale
    import lppe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_pixel  i_pixel,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_scaled      o_scaled
);

    logic        r_v1, r_v2, r_v3;
    logic        r1_mode, r2_mode, r3_mode;
    logic [7:0]  r1_abs;
    logic [15:0] r1_pr [3];
    logic [23:0] r2_p  [3];
    logic [7:0]  r3_b  [3];
    logic [7:0]  n3_b  [3];
    logic [40:0] w_quot [3];
    logic        w_en1, w_en2, w_en3;

    // Advance a stage when it is empty or its contents move on
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: channel times relative level
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_mode  <= i_pixel.mode;
            r1_abs   <= i_pixel.absolute_level;
            r1_pr[0] <= 16'(i_pixel.red)   * 16'(i_pixel.relative_level);
            r1_pr[1] <= 16'(i_pixel.green) * 16'(i_pixel.relative_level);
            r1_pr[2] <= 16'(i_pixel.blue)  * 16'(i_pixel.relative_level);
        end
    end

    // Stage 2: times absolute level
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_mode <= r1_mode;
            for (int i = 0; i < 3; i++) begin
                r2_p[i] <= 24'(r1_pr[i]) * 24'(r1_abs);
            end
        end
    end

    // Stage 3: divide by 2550 and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_quot[i] = 41'(r2_p[i][19:0]) * 41'(RECIP);
            n3_b[i]   = (r2_p[i] >= SAT_LIMIT) ? CH_MAX : w_quot[i][39:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_mode <= r2_mode;
            for (int i = 0; i < 3; i++) begin
                r3_b[i] <= n3_b[i];
            end
        end
    end

    assign o_valid        = r_v3;
    assign o_scaled.blank = r3_mode;
    assign o_scaled.red   = r3_b[0];
    assign o_scaled.green = r3_b[1];
    assign o_scaled.blue  = r3_b[2];

endmodule

`default_nettype wire

// ===== rtl/lppe_serial.sv =====
// ----------------------------------------------------------------------------
// lppe_serial
// Packs the scaled bytes in wire order and shifts them out MSB first as 24
// timer compare words from an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_serial
    import lppe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_scaled i_scaled,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_word        o_word
);

    logic        r_vld;
    logic        r_blank;
    logic [4:0]  r_cnt;
    logic [23:0] r_shift;
    logic [23:0] w_packed;
    logic        w_take;
    logic        w_load;

    // Arrange the three bytes in wire order
    always_comb begin
        case (i_cfg.color_order)
            ORDER_RGB: w_packed = {i_scaled.red,   i_scaled.green, i_scaled.blue};
            ORDER_RBG: w_packed = {i_scaled.red,   i_scaled.blue,  i_scaled.green};
            ORDER_BRG: w_packed = {i_scaled.blue,  i_scaled.red,   i_scaled.green};
            ORDER_GRB: w_packed = {i_scaled.green, i_scaled.red,   i_scaled.blue};
            default:   w_packed = {i_scaled.green, i_scaled.red,   i_scaled.blue};
        endcase
    end

    assign w_take  = r_vld && !i_stall;
    assign o_ready = !r_vld || (w_take && (r_cnt == LAST_BIT));
    assign w_load  = i_valid && o_ready;

    // Control: valid and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cnt <= '0;
        end else if (w_load) begin
            r_vld <= 1'b1;
            r_cnt <= '0;
        end else if (w_take) begin
            if (r_cnt == LAST_BIT) begin
                r_vld <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Payload: load a new item or shift to the next bit
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_shift <= w_packed;
            r_blank <= i_scaled.blank;
        end else if (w_take) begin
            r_shift <= {r_shift[22:0], 1'b0};
        end
    end

    assign o_valid     = r_vld;
    assign o_word.duty = r_blank    ? 16'd0 :
                         r_shift[23] ? i_cfg.one_bit_duty : i_cfg.zero_bit_duty;
    assign o_word.last = (r_cnt == LAST_BIT);

`ifndef SYNTH
    // A taken word that is not the last moves to the next bit
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (r_cnt != LAST_BIT)) |=>
            (r_vld && (r_cnt == 5'($past(r_cnt) + 5'd1))))
        else $error("bit counter did not advance");

    // A stalled word keeps its bit position and valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && i_stall && !w_load) |=> (r_vld && $stable(r_cnt)))
        else $error("stalled word lost its slot");

    // A new item loads only into an empty register or behind the last word
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_vld || (!i_stall && (r_cnt == LAST_BIT))))
        else $error("item loaded over a word in flight");
`endif

endmodule

`default_nettype wire

// ===== rtl/led_pixel_pwm_encoder_core.sv =====
// Path: the three scaling stage registers, then the serializer output register.
// Throughput: one compare word per cycle while i_stall is low; the bit
// serializer emitting each word from its output register sets this rate.
// The three scaling stages hold up to three further items while words go out.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// led_pixel_pwm_encoder_core
// Scales each pixel by two brightness factors and encodes it as 24 timer
// compare words in the configured colour order; blank items give zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pixel_pwm_encoder_core
    import lppe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_pixel      i_pixel,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_word            o_word
);

    t_cfg    r_cfg;
    t_scaled w_scaled;
    logic    w_sc_valid;
    logic    w_ser_ready;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_order   <= RST_COLOR_ORDER;
            r_cfg.zero_bit_duty <= RST_ZERO_DUTY;
            r_cfg.one_bit_duty  <= RST_ONE_DUTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLOR_ORDER: r_cfg.color_order   <= i_cfg_data[1:0];
                CFG_ZERO_DUTY:   r_cfg.zero_bit_duty <= i_cfg_data;
                CFG_ONE_DUTY:    r_cfg.one_bit_duty  <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    lppe_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pixel  (i_pixel),
        .o_valid  (w_sc_valid),
        .i_ready  (w_ser_ready),
        .o_scaled (w_scaled)
    );

    lppe_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_sc_valid),
        .o_ready  (w_ser_ready),
        .i_scaled (w_scaled),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word)
    );

endmodule

`default_nettype wire
